### hdl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`default_nettype none
package qrs_pkg;

    localparam int DEF_COEF_WIDTH = 16;
    localparam int ROOT_FRAC      = 16;
    localparam int OUT_W          = 32;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Per-item control bits that ride along with the data.
    typedef struct packed {
        logic       neg;    // discriminant is negative
        logic       msign;  // -b/(2a) is positive
        logic       deg;    // coefficient a is zero
        logic [1:0] count;  // real root count, final value
    } t_ctl;

endpackage
`default_nettype wire

### hdl/qrs_disc.sv
// Two-stage discriminant unit: magnitudes, products, then sign and magnitude of b*b-4ac.
`default_nettype none
module qrs_disc #(
    parameter int COEF_WIDTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [COEF_WIDTH-1:0]     i_a,
    input  wire logic [COEF_WIDTH-1:0]     i_b,
    input  wire logic [COEF_WIDTH-1:0]     i_c,
    output logic                           o_valid,
    output logic [2*COEF_WIDTH:0]          o_dmag,
    output logic [COEF_WIDTH:0]            o_den,
    output logic [COEF_WIDTH-1:0]          o_absb,
    output qrs_pkg::t_ctl                  o_ctl
);
    import qrs_pkg::*;

    localparam int W = COEF_WIDTH;

    logic           r1_v;
    logic [W-1:0]   r1_absa, r1_absb;
    logic [2*W-1:0] r1_p, r1_q;
    logic           r1_opp, r1_msign, r1_deg, r1_degcnt;

    logic [W-1:0]   n_absa, n_absb, n_absc;

    logic           r2_v;
    logic [2*W:0]   r2_dmag;
    logic [W:0]     r2_den;
    logic [W-1:0]   r2_absb;
    t_ctl           r2_ctl;

    logic [2*W+1:0] n_q4, n_p, n_d;
    t_ctl           n_ctl;

    always_comb begin
        n_absa = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        n_absb = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        n_absc = i_c[W-1] ? (~i_c + 1'b1) : i_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_absa   <= n_absa;
        r1_absb   <= n_absb;
        r1_p      <= n_absb * n_absb;
        r1_q      <= n_absa * n_absc;
        r1_opp    <= i_a[W-1] != i_c[W-1];
        r1_msign  <= i_b[W-1] != i_a[W-1];
        r1_deg    <= i_a == '0;
        r1_degcnt <= !(i_b == '0 && i_c != '0);
    end

    always_comb begin
        n_q4 = {r1_q, 2'b00};
        n_p  = {2'b00, r1_p};
        n_ctl.msign = r1_msign;
        n_ctl.deg   = r1_deg;
        if (r1_opp && r1_q != '0) begin
            n_d       = n_p + n_q4;
            n_ctl.neg = 1'b0;
        end else if (n_q4 > n_p) begin
            n_d       = n_q4 - n_p;
            n_ctl.neg = 1'b1;
        end else begin
            n_d       = n_p - n_q4;
            n_ctl.neg = 1'b0;
        end
        if (r1_deg) begin
            n_ctl.count = r1_degcnt ? CNT_ONE : CNT_NONE;
        end else if (n_ctl.neg) begin
            n_ctl.count = CNT_NONE;
        end else if (n_d == '0) begin
            n_ctl.count = CNT_ONE;
        end else begin
            n_ctl.count = CNT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_dmag <= n_d[2*W:0];
        r2_den  <= {r1_absa, 1'b0};
        r2_absb <= r1_absb;
        r2_ctl  <= n_ctl;
    end

    assign o_valid = r2_v;
    assign o_dmag  = r2_dmag;
    assign o_den   = r2_den;
    assign o_absb  = r2_absb;
    assign o_ctl   = r2_ctl;

endmodule
`default_nettype wire

### hdl/qrs_sqrt.sv
// Pipelined restoring square root, one result bit per register stage.
`default_nettype none
module qrs_sqrt #(
    parameter int STEPS = 33
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [2*STEPS-1:0]   i_rad,
    output logic                      o_valid,
    output logic [STEPS-1:0]          o_root
);
    localparam int S  = STEPS;
    localparam int RW = S + 2;
    localparam int XW = 2 * S;

    logic [XW-1:0] x_in   [S];
    logic [RW-1:0] rem_in [S];
    logic [S-1:0]  q_in   [S];
    logic          v_in   [S];

    logic [XW-1:0] r_x    [S];
    logic [RW-1:0] r_rem  [S];
    logic [S-1:0]  r_q    [S];
    logic          r_v    [S];

    for (genvar k = 0; k < S; k++) begin : g_stage
        logic [RW-1:0] n_shift, n_trial, n_rem;
        logic [S-1:0]  n_q;

        if (k == 0) begin : g_first
            assign x_in[k]   = i_rad;
            assign rem_in[k] = '0;
            assign q_in[k]   = '0;
            assign v_in[k]   = i_valid;
        end else begin : g_next
            assign x_in[k]   = r_x[k-1];
            assign rem_in[k] = r_rem[k-1];
            assign q_in[k]   = r_q[k-1];
            assign v_in[k]   = r_v[k-1];
        end

        always_comb begin
            n_shift = {rem_in[k][RW-3:0], x_in[k][2*(S-1-k)+1 -: 2]};
            n_trial = {q_in[k], 2'b01};
            if (n_shift >= n_trial) begin
                n_rem = n_shift - n_trial;
                n_q   = {q_in[k][S-2:0], 1'b1};
            end else begin
                n_rem = n_shift;
                n_q   = {q_in[k][S-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k]   <= x_in[k];
            r_rem[k] <= n_rem;
            r_q[k]   <= n_q;
        end
    end

    assign o_valid = r_v[S-1];
    assign o_root  = r_q[S-1];

endmodule
`default_nettype wire

### hdl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per register stage, truncating.
`default_nettype none
module qrs_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output logic                    o_valid,
    output logic [NUM_W-1:0]        o_quot
);
    localparam int NW = NUM_W;
    localparam int DW = DEN_W;

    logic [NW-1:0] n_in   [NW];
    logic [DW-1:0] d_in   [NW];
    logic [DW:0]   rem_in [NW];
    logic [NW-1:0] q_in   [NW];
    logic          v_in   [NW];

    logic [NW-1:0] r_n    [NW];
    logic [DW-1:0] r_d    [NW];
    logic [DW:0]   r_rem  [NW];
    logic [NW-1:0] r_q    [NW];
    logic          r_v    [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0]   n_shift, n_rem;
        logic [NW-1:0] n_q;

        if (k == 0) begin : g_first
            assign n_in[k]   = i_num;
            assign d_in[k]   = i_den;
            assign rem_in[k] = '0;
            assign q_in[k]   = '0;
            assign v_in[k]   = i_valid;
        end else begin : g_next
            assign n_in[k]   = r_n[k-1];
            assign d_in[k]   = r_d[k-1];
            assign rem_in[k] = r_rem[k-1];
            assign q_in[k]   = r_q[k-1];
            assign v_in[k]   = r_v[k-1];
        end

        always_comb begin
            n_shift = {rem_in[k][DW-1:0], n_in[k][NW-1-k]};
            if (n_shift >= {1'b0, d_in[k]}) begin
                n_rem = n_shift - {1'b0, d_in[k]};
                n_q   = {q_in[k][NW-2:0], 1'b1};
            end else begin
                n_rem = n_shift;
                n_q   = {q_in[k][NW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[k]   <= n_in[k];
            r_d[k]   <= d_in[k];
            r_rem[k] <= n_rem;
            r_q[k]   <= n_q;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_q[NW-1];

endmodule
`default_nettype wire

### hdl/quadratic_root_solver.sv
// Pipeline from start to o_done: two discriminant stages, one square root stage per
// root bit, one divider stage per quotient bit, and one output stage.
// Throughput: one coefficient set per cycle; the receiver cannot stall, so busy is
// low whenever reset is released. Synchronous reset clears every valid bit in flight
// and holds busy high while it is asserted.
`default_nettype none
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::DEF_COEF_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [COEF_WIDTH-1:0]      i_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]      i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]      i_coef_c,
    output logic                                   o_done,
    output logic [1:0]                             o_real_root_count,
    output logic                                   o_degenerate,
    output logic signed [qrs_pkg::OUT_W-1:0]       o_root_low_real,
    output logic signed [qrs_pkg::OUT_W-1:0]       o_root_high_real,
    output logic signed [qrs_pkg::OUT_W-1:0]       o_root_low_imag,
    output logic signed [qrs_pkg::OUT_W-1:0]       o_root_high_imag,
    output logic                                   o_overflow
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int S   = W + 17;
    localparam int EW  = (S + 2 > OUT_W + 1) ? S + 2 : OUT_W + 1;
    localparam int SBW = (W + 1) + W + $bits(t_ctl);

    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO =
        {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    function automatic logic [OUT_W:0] f_sat(input logic signed [EW-1:0] v);
        if (v > SAT_HI) begin
            return {1'b1, SAT_HI[OUT_W-1:0]};
        end else if (v < SAT_LO) begin
            return {1'b1, SAT_LO[OUT_W-1:0]};
        end
        return {1'b0, v[OUT_W-1:0]};
    endfunction

    logic           d_valid;
    logic [2*W:0]   d_mag;
    logic [W:0]     d_den;
    logic [W-1:0]   d_absb;
    t_ctl           d_ctl;

    logic           s_valid;
    logic [S-1:0]   s_root;

    logic [SBW-1:0] r_sb1 [S];
    logic [W:0]     sb_den;
    logic [W-1:0]   sb_absb;
    t_ctl           sb_ctl;

    t_ctl           r_sb2 [S];

    logic           h_valid, m_valid;
    logic [S-1:0]   h_quot, m_quot;

    assign busy = !i_rst_n;

    qrs_disc #(.COEF_WIDTH(W)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_valid (d_valid),
        .o_dmag  (d_mag),
        .o_den   (d_den),
        .o_absb  (d_absb),
        .o_ctl   (d_ctl)
    );

    qrs_sqrt #(.STEPS(S)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_rad   ({1'b0, d_mag, 32'b0}),
        .o_valid (s_valid),
        .o_root  (s_root)
    );

    always_ff @(posedge i_clk) begin
        r_sb1[0] <= {d_den, d_absb, d_ctl};
        for (int k = 1; k < S; k++) begin
            r_sb1[k] <= r_sb1[k-1];
        end
    end

    assign {sb_den, sb_absb, sb_ctl} = r_sb1[S-1];

    qrs_div #(.NUM_W(S), .DEN_W(W + 1)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_num   (s_root),
        .i_den   (sb_den),
        .o_valid (h_valid),
        .o_quot  (h_quot)
    );

    qrs_div #(.NUM_W(S), .DEN_W(W + 1)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_num   ({1'b0, sb_absb, {ROOT_FRAC{1'b0}}}),
        .i_den   (sb_den),
        .o_valid (m_valid),
        .o_quot  (m_quot)
    );

    always_ff @(posedge i_clk) begin
        r_sb2[0] <= sb_ctl;
        for (int k = 1; k < S; k++) begin
            r_sb2[k] <= r_sb2[k-1];
        end
    end

    t_ctl                  f_ctl;
    logic signed [EW-1:0]  n_m, n_h, n_lr, n_hr, n_li, n_hi;
    logic [OUT_W:0]        n_slr, n_shr, n_sli, n_shi;

    logic                  r_done;
    logic [1:0]            r_count;
    logic                  r_deg, r_ov;
    logic [OUT_W-1:0]      r_lr, r_hr, r_li, r_hi;

    always_comb begin
        f_ctl = r_sb2[S-1];
        n_h   = EW'(h_quot);
        n_m   = f_ctl.msign ? EW'(m_quot) : -EW'(m_quot);
        if (f_ctl.neg) begin
            n_lr = n_m;
            n_hr = n_m;
            n_li = -n_h;
            n_hi = n_h;
        end else begin
            n_lr = n_m - n_h;
            n_hr = n_m + n_h;
            n_li = '0;
            n_hi = '0;
        end
        n_slr = f_sat(n_lr);
        n_shr = f_sat(n_hr);
        n_sli = f_sat(n_li);
        n_shi = f_sat(n_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= h_valid && m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= f_ctl.count;
        r_deg   <= f_ctl.deg;
        if (f_ctl.deg) begin
            r_lr <= '0;
            r_hr <= '0;
            r_li <= '0;
            r_hi <= '0;
            r_ov <= 1'b0;
        end else begin
            r_lr <= n_slr[OUT_W-1:0];
            r_hr <= n_shr[OUT_W-1:0];
            r_li <= n_sli[OUT_W-1:0];
            r_hi <= n_shi[OUT_W-1:0];
            r_ov <= n_slr[OUT_W] | n_shr[OUT_W] | n_sli[OUT_W] | n_shi[OUT_W];
        end
    end

    assign o_done            = r_done;
    assign o_real_root_count = r_count;
    assign o_degenerate      = r_deg;
    assign o_root_low_real   = r_lr;
    assign o_root_high_real  = r_hr;
    assign o_root_low_imag   = r_li;
    assign o_root_high_imag  = r_hi;
    assign o_overflow        = r_ov;

endmodule
`default_nettype wire

### hdl/qrs_checker.sv
// Port-level checks on the result beats of the quadratic root solver, and their binding.
`default_nettype none
module qrs_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_done,
    input  wire logic [1:0]                        o_real_root_count,
    input  wire logic                              o_degenerate,
    input  wire logic signed [qrs_pkg::OUT_W-1:0]  o_root_low_real,
    input  wire logic signed [qrs_pkg::OUT_W-1:0]  o_root_high_real,
    input  wire logic signed [qrs_pkg::OUT_W-1:0]  o_root_low_imag,
    input  wire logic signed [qrs_pkg::OUT_W-1:0]  o_root_high_imag,
    input  wire logic                              o_overflow
);
    import qrs_pkg::*;

    // A degenerate beat carries no roots and can never have saturated.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |->
            o_root_low_real == 0 && o_root_high_real == 0 &&
            o_root_low_imag == 0 && o_root_high_imag == 0 && !o_overflow)
        else $error("degenerate beat with nonzero root fields");

    // A degenerate beat never reports two real roots.
    a_degenerate_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |->
            o_real_root_count == CNT_NONE || o_real_root_count == CNT_ONE)
        else $error("degenerate beat with bad root count");

    // A complex pair shares its real part and has imaginary parts of opposite sign.
    a_complex_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_degenerate && o_real_root_count == CNT_NONE |->
            o_root_low_real == o_root_high_real &&
            o_root_low_imag <= 0 && o_root_high_imag >= 0)
        else $error("complex pair out of order");

    // Real roots come out ordered with zero imaginary parts.
    a_real_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_degenerate && o_real_root_count != CNT_NONE |->
            o_root_low_real <= o_root_high_real &&
            o_root_low_imag == 0 && o_root_high_imag == 0)
        else $error("real roots out of order");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
`default_nettype wire
